FILE: hw/rtl/pse_pkg.sv
// Shared types, constants and helper functions of the permutation shuffle engine.
`timescale 1ns / 1ps

package pse_pkg;

  // Table geometry and field widths.
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = 6;
  localparam int SIZE_W      = 7;
  localparam int RAND_W      = 31;
  localparam int DIV_CNT_W   = $clog2(RAND_W);

  // Operation codes carried in the operation field.
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_SHUFFLE = 2'd1,
    OP_SWAP    = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]        operation;
    logic [RAND_W-1:0] random_a;
    logic [RAND_W-1:0] random_b;
    logic [IDX_W-1:0]  read_index;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [IDX_W-1:0] entry_value;
    logic             pass_done;
    logic [IDX_W-1:0] current_position;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the accepted transaction
    logic load_wr;     // write one identity entry
    logic div_step;    // one remainder iteration
    logic div_to_a;    // final remainder becomes the first swap address
    logic div_to_b;    // final remainder becomes the second swap address
    logic div_reload;  // restart the remainder unit on random_b
    logic rd_a;        // read the first swap entry
    logic rd_b;        // read the second swap entry
    logic latch_a;     // hold the first swap entry
    logic wr_a;        // write the second entry's value at the first address
    logic wr_b;        // write the first entry's value at the second address
    logic rd_e;        // read the requested entry
    logic finish;      // update position and load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;   // remainder unit is on its last iteration
    logic load_last;  // identity load is writing the last entry in use
    op_t  op;         // operation of the transaction in flight
  } dp_status_t;

  // Last index in use: the table size clamped to 2..TABLE_DEPTH, minus one.
  function automatic logic [IDX_W-1:0] last_index(input logic [SIZE_W-1:0] size);
    logic [IDX_W-1:0] res;
    if (size < SIZE_W'(2)) begin
      res = IDX_W'(1);
    end else if (size > SIZE_W'(TABLE_DEPTH)) begin
      res = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      res = IDX_W'(size - SIZE_W'(1));
    end
    return res;
  endfunction

  // Shuffle position the next step uses; zero or out of range restarts the pass.
  function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] pos,
                                                input logic [IDX_W-1:0] n_m1);
    logic [IDX_W-1:0] res;
    if (pos == '0 || pos > n_m1) begin
      res = n_m1;
    end else begin
      res = pos;
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/pse_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/pse_ctrl.sv
// Controller state machine that sequences each operation of the shuffle engine.
`timescale 1ns / 1ps

module pse_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_op,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  pse_pkg::dp_status_t status,
  output pse_pkg::ctrl_cmd_t  cmd
);

  import pse_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_LOAD   = 10'b00_0000_0010,
    ST_MOD_A  = 10'b00_0000_0100,
    ST_MOD_B  = 10'b00_0000_1000,
    ST_RD_A   = 10'b00_0001_0000,
    ST_RD_B   = 10'b00_0010_0000,
    ST_WR_A   = 10'b00_0100_0000,
    ST_WR_B   = 10'b00_1000_0000,
    ST_READ   = 10'b01_0000_0000,
    ST_FINISH = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The result register can take a new transaction when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (op_t'(in_op))
            OP_LOAD:    state_nxt = ST_LOAD;
            OP_SHUFFLE: state_nxt = ST_MOD_A;
            OP_SWAP:    state_nxt = ST_MOD_A;
            default:    state_nxt = ST_READ;
          endcase
        end
      end
      ST_LOAD: begin
        cmd.load_wr = 1'b1;
        if (status.load_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_MOD_A: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          if (status.op == OP_SWAP) begin
            cmd.div_to_a   = 1'b1;
            cmd.div_reload = 1'b1;
            state_nxt      = ST_MOD_B;
          end else begin
            cmd.div_to_b = 1'b1;
            state_nxt    = ST_RD_A;
          end
        end
      end
      ST_MOD_B: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          cmd.div_to_b = 1'b1;
          state_nxt    = ST_RD_A;
        end
      end
      ST_RD_A: begin
        cmd.rd_a  = 1'b1;
        state_nxt = ST_RD_B;
      end
      ST_RD_B: begin
        cmd.rd_b    = 1'b1;
        cmd.latch_a = 1'b1;
        state_nxt   = ST_WR_A;
      end
      ST_WR_A: begin
        cmd.wr_a  = 1'b1;
        state_nxt = ST_WR_B;
      end
      ST_WR_B: begin
        cmd.wr_b  = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_READ: begin
        cmd.rd_e  = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result valid is set on finish and cleared when the transaction is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/pse_dp.sv
// Datapath: table RAM, remainder unit, shuffle position and result register.
`timescale 1ns / 1ps

module pse_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [pse_pkg::SIZE_W-1:0] cfg_wr_data,
  input  pse_pkg::in_item_t      in_data,
  input  pse_pkg::ctrl_cmd_t     cmd,
  output pse_pkg::dp_status_t    status,
  output pse_pkg::out_item_t     out_data
);

  import pse_pkg::*;

  logic [SIZE_W-1:0]    size_r;
  logic [IDX_W-1:0]     n_m1;
  logic [IDX_W-1:0]     pos_r;
  op_t                  op_r;
  logic [RAND_W-1:0]    rb_r;
  logic [IDX_W-1:0]     ridx_r;
  logic                 in_range_r;
  logic [IDX_W-1:0]     i_r;
  logic [IDX_W-1:0]     cnt_r;
  logic [RAND_W-1:0]    div_q_r;
  logic [SIZE_W-1:0]    rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [IDX_W-1:0]     addr_a_r;
  logic [IDX_W-1:0]     addr_b_r;
  logic [IDX_W-1:0]     data_a_r;
  out_item_t            out_r;

  logic [SIZE_W-1:0]    divisor;
  logic [SIZE_W-1:0]    rem_shift;
  logic [SIZE_W-1:0]    rem_nxt;
  logic [IDX_W-1:0]     pos_nxt;
  logic                 step_done;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [IDX_W-1:0]     ram_wdata;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [IDX_W-1:0]     ram_rdata;

  // Table size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_W'(TABLE_DEPTH);
    end else if (cfg_wr_en) begin
      size_r <= cfg_wr_data;
    end
  end

  assign n_m1 = last_index(size_r);

  // One restoring remainder iteration: shift in a dividend bit, subtract if it fits.
  assign divisor   = (op_r == OP_SHUFFLE) ? ({1'b0, i_r} + SIZE_W'(1)) : ({1'b0, n_m1} + SIZE_W'(1));
  assign rem_shift = {rem_r[SIZE_W-2:0], div_q_r[RAND_W-1]};
  assign rem_nxt   = (rem_shift >= divisor) ? (rem_shift - divisor) : rem_shift;

  // Transaction capture, remainder unit and swap address registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= op_t'(in_data.operation);
      rb_r       <= in_data.random_b;
      ridx_r     <= in_data.read_index;
      in_range_r <= (in_data.read_index <= n_m1);
      i_r        <= next_pos(pos_r, n_m1);
      addr_a_r   <= next_pos(pos_r, n_m1);
      cnt_r      <= '0;
      div_q_r    <= in_data.random_a;
      rem_r      <= '0;
      div_cnt_r  <= DIV_CNT_W'(RAND_W - 1);
    end else begin
      if (cmd.load_wr) begin
        cnt_r <= cnt_r + IDX_W'(1);
      end
      if (cmd.div_reload) begin
        div_q_r   <= rb_r;
        rem_r     <= '0;
        div_cnt_r <= DIV_CNT_W'(RAND_W - 1);
      end else if (cmd.div_step) begin
        div_q_r   <= {div_q_r[RAND_W-2:0], 1'b0};
        rem_r     <= rem_nxt;
        div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
      end
      if (cmd.div_to_a) begin
        addr_a_r <= rem_nxt[IDX_W-1:0];
      end
      if (cmd.div_to_b) begin
        addr_b_r <= rem_nxt[IDX_W-1:0];
      end
    end
  end

  // Hold the first swap entry while the second one is read.
  always_ff @(posedge clk) begin
    if (cmd.latch_a) begin
      data_a_r <= ram_rdata;
    end
  end

  // Table RAM port selection.
  assign ram_we    = cmd.load_wr || cmd.wr_a || cmd.wr_b;
  assign ram_waddr = cmd.load_wr ? cnt_r : (cmd.wr_a ? addr_a_r : addr_b_r);
  assign ram_wdata = cmd.load_wr ? cnt_r : (cmd.wr_a ? ram_rdata : data_a_r);
  assign ram_re    = cmd.rd_a || cmd.rd_b || cmd.rd_e;
  assign ram_raddr = cmd.rd_a ? addr_a_r : (cmd.rd_b ? addr_b_r : ridx_r);

  pse_ram #(
    .WIDTH (IDX_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shuffle position after this transaction.
  assign step_done = (op_r == OP_SHUFFLE) && (i_r <= IDX_W'(1));

  always_comb begin
    pos_nxt = pos_r;
    if (op_r == OP_LOAD) begin
      pos_nxt = '0;
    end else if (op_r == OP_SHUFFLE) begin
      pos_nxt = step_done ? '0 : (i_r - IDX_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.finish) begin
      pos_r <= pos_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.entry_value      <= ((op_r == OP_READ) && in_range_r) ? ram_rdata : '0;
      out_r.pass_done        <= step_done;
      out_r.current_position <= next_pos(pos_nxt, n_m1);
    end
  end

  assign out_data         = out_r;
  assign status.div_last  = (div_cnt_r == '0);
  assign status.load_last = (cnt_r == n_m1);
  assign status.op        = op_r;

endmodule

FILE: hw/rtl/permutation_shuffle_engine.sv
// Top level of the permutation shuffle engine: controller, datapath and checks.
`timescale 1ns / 1ps

// The engine keeps a permutation table in a RAM with one write port and one
// registered read port, and runs one operation per transaction: load identity,
// one Fisher-Yates step, random swap, or read one entry. It takes one
// transaction at a time; the result register lets a new transaction enter
// while the previous result still waits. A load identity makes one RAM write
// per entry. A shuffle step takes one modulo and a random swap two, on a
// remainder unit that retires one dividend bit per cycle, then two reads and
// two writes on the RAM; a read entry makes one RAM read. The table must be
// loaded before entries are read or swapped.

module permutation_shuffle_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [pse_pkg::SIZE_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  pse_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output pse_pkg::out_item_t         out_data
);

  import pse_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  pse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.operation),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  pse_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .status      (status),
    .out_data    (out_data)
  );

  // An accepted transaction keeps the input stalled on the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // At most one source drives the table write port.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_wr, cmd.wr_a, cmd.wr_b}))
    else $error("conflicting table writes");

  // A finished transaction shows up as a valid result.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("finished transaction not presented");

  // The reported shuffle position is never zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.current_position != '0))
    else $error("current position is zero");

endmodule

FILE: verif/permutation_shuffle_engine_tb.sv
// Self-checking testbench for the permutation shuffle engine.
`timescale 1ns / 1ps

module permutation_shuffle_engine_tb;
  import pse_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int MIX_ITEMS      = 30;
  localparam logic [RAND_W-1:0] WORD_MAX = '1;

  // Receiver stall patterns.
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  // Tracks the permutation table and the shuffle position, and holds the
  // replies still owed by the engine in acceptance order.
  class shuffle_checker_t;
    logic [IDX_W-1:0]  entries [TABLE_DEPTH];
    logic [IDX_W-1:0]  position;
    logic [SIZE_W-1:0] size_setting;
    out_item_t         awaited_replies [$];
    int                errors;
    int                taken;

    function new();
      foreach (entries[k]) entries[k] = '0;
      position     = '0;
      size_setting = SIZE_W'(TABLE_DEPTH);
      errors       = 0;
      taken        = 0;
    endfunction

    // Entries in use: the size setting held to the range 2..TABLE_DEPTH.
    function int unsigned active_size();
      int unsigned n;
      n = size_setting;
      if (n < 2) n = 2;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      return n;
    endfunction

    // Position of the next shuffle step; zero or a stale position restarts at n-1.
    function int unsigned step_position(int unsigned n);
      if (position == 0 || position > n - 1) return n - 1;
      return position;
    endfunction

    function void exchange(int unsigned a, int unsigned b);
      logic [IDX_W-1:0] held;
      held       = entries[a];
      entries[a] = entries[b];
      entries[b] = held;
    endfunction

    // Apply one accepted transaction to the table and queue the reply it owes.
    function void note_input(in_item_t t);
      int unsigned n, i, k;
      out_item_t   reply;
      n     = active_size();
      reply = '0;
      taken++;
      case (op_t'(t.operation))
        OP_LOAD: begin
          for (k = 0; k < n; k++) entries[k] = IDX_W'(k);
          position = '0;
        end
        OP_SHUFFLE: begin
          i = step_position(n);
          exchange(i, t.random_a % (i + 1));
          if (i <= 1) begin
            reply.pass_done = 1'b1;
            position        = '0;
          end else begin
            position = IDX_W'(i - 1);
          end
        end
        OP_SWAP: exchange(t.random_a % n, t.random_b % n);
        default: begin
          if (t.read_index < n) reply.entry_value = entries[t.read_index];
        end
      endcase
      reply.current_position = IDX_W'(step_position(n));
      awaited_replies.push_back(reply);
    endfunction

    // Compare one result transaction with the oldest owed reply.
    task check_result(out_item_t got);
      out_item_t want;
      if (awaited_replies.size() == 0) begin
        report($sformatf("result with none owed: value %0d done %0d position %0d",
                         got.entry_value, got.pass_done, got.current_position));
        return;
      end
      want = awaited_replies.pop_front();
      if (got.entry_value !== want.entry_value)
        report($sformatf("entry_value got %0d want %0d", got.entry_value, want.entry_value));
      if (got.pass_done !== want.pass_done)
        report($sformatf("pass_done got %0d want %0d", got.pass_done, want.pass_done));
      if (got.current_position !== want.current_position)
        report($sformatf("current_position got %0d want %0d",
                         got.current_position, want.current_position));
    endtask

    task report(string msg);
      errors++;
      $display("[%0t] ERROR: %s", $time, msg);
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [SIZE_W-1:0] cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;

  shuffle_checker_t chk = new();
  int               idle_cycles  = 0;
  int               burst_left   = 0;
  bit               hold_request = 1'b0;

  permutation_shuffle_engine dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  // Free-running clock.
  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  // Note every accepted transaction on both channels and watch for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) chk.note_input(in_data);
      if (out_valid && !out_stall) chk.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("permutation_shuffle_engine: mismatch");
        $finish;
      end
    end
  end

  // Receiver: stall patterns in random segments, plus one long hold-off on request.
  initial begin : receiver
    int          seg_left;
    stall_mode_t mode;
    seg_left = 0;
    mode     = STALL_NONE;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          mode     = stall_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(8, 80);
        end
        seg_left--;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ~out_stall;
        endcase
        @(posedge clk);
      end
    end
  end

  // Random word biased toward the extremes and small values.
  function automatic logic [RAND_W-1:0] pick_word();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? WORD_MAX : '0;
      1:       return RAND_W'($urandom_range(0, 255));
      default: return RAND_W'($urandom);
    endcase
  endfunction

  function automatic in_item_t item_of(op_t op, logic [RAND_W-1:0] a,
                                       logic [RAND_W-1:0] b, logic [IDX_W-1:0] idx);
    in_item_t item;
    item.operation  = op;
    item.random_a   = a;
    item.random_b   = b;
    item.read_index = idx;
    return item;
  endfunction

  // Random transaction of the given operation; reads mostly land inside the table.
  function automatic in_item_t make_item(op_t op);
    logic [IDX_W-1:0] idx;
    if (op == OP_READ && $urandom_range(0, 4) != 0)
      idx = IDX_W'($urandom_range(0, chk.active_size() - 1));
    else
      idx = IDX_W'($urandom);
    return item_of(op, pick_word(), pick_word(), idx);
  endfunction

  // Offer one transaction; when a burst runs out, a random gap comes three times in four.
  task automatic send_item(input in_item_t item);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait until every owed reply has come back.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (chk.awaited_replies.size() != 0);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    chk.size_setting = value;
  endtask

  // One size setting: a full pass from a fresh identity, then a random mix.
  task automatic run_phase(input logic [SIZE_W-1:0] size, input bit squeeze);
    int unsigned n, s, pick;
    write_size(size);
    n = chk.active_size();
    send_item(make_item(OP_LOAD));
    for (s = 1; s < n; s++) begin
      send_item(make_item(OP_SHUFFLE));
      if ($urandom_range(0, 3) == 0) send_item(make_item(OP_READ));
    end
    if (squeeze) hold_request = 1'b1;
    // The shuffle position left by the mix carries into the next setting.
    repeat (MIX_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) send_item(make_item(OP_LOAD));
      else if (pick < 50) send_item(make_item(OP_SHUFFLE));
      else if (pick < 70) send_item(make_item(OP_SWAP));
      else send_item(make_item(OP_READ));
    end
  endtask

  initial begin : stimulus
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: full-size load, then the extremes of every operation.
    send_item(item_of(OP_LOAD, WORD_MAX, WORD_MAX, '1));
    send_item(item_of(OP_READ, '0, '0, '0));
    send_item(item_of(OP_READ, '0, '0, '1));
    send_item(item_of(OP_SHUFFLE, '0, '0, '0));
    send_item(item_of(OP_SHUFFLE, WORD_MAX, '0, '0));
    send_item(item_of(OP_SWAP, RAND_W'(5), RAND_W'(5), '0));
    send_item(item_of(OP_SWAP, '0, WORD_MAX, '0));
    send_item(item_of(OP_READ, '0, '0, '1));
    send_item(item_of(OP_READ, '0, '0, '0));

    // Shrink mid-pass: the stale position is pulled back to the last entry.
    write_size(7'd2);
    send_item(item_of(OP_SHUFFLE, RAND_W'(1), '0, '0));
    send_item(item_of(OP_SHUFFLE, '0, '0, '0));
    send_item(item_of(OP_READ, '0, '0, IDX_W'(1)));
    send_item(item_of(OP_READ, '0, '0, IDX_W'(2)));
    send_item(item_of(OP_READ, '0, '0, '1));
    send_item(item_of(OP_LOAD, '0, '0, '0));

    // Oversized setting: entries above the small load keep their old values.
    write_size(7'd127);
    send_item(item_of(OP_READ, '0, '0, '1));
    send_item(item_of(OP_READ, '0, '0, IDX_W'(2)));
    send_item(item_of(OP_SWAP, WORD_MAX, '0, '0));

    // Undersized settings act as two entries.
    write_size(7'd0);
    send_item(item_of(OP_SHUFFLE, WORD_MAX, '0, '0));
    send_item(item_of(OP_SWAP, RAND_W'(3), RAND_W'(2), '0));
    write_size(7'd1);
    send_item(item_of(OP_READ, '0, '0, IDX_W'(1)));
    send_item(item_of(OP_SHUFFLE, RAND_W'(2), '0, '0));

    // Random phases across many sizes, extremes among them.
    run_phase(7'd3, 1'b0);
    run_phase(7'd64, 1'b1);
    run_phase(7'd1, 1'b0);
    run_phase(7'd17, 1'b0);
    run_phase(7'd127, 1'b0);
    run_phase(7'd8, 1'b0);
    run_phase(7'd65, 1'b0);
    run_phase(7'd2, 1'b0);
    run_phase(7'd40, 1'b0);
    run_phase(7'd0, 1'b0);
    run_phase(7'd5, 1'b0);
    run_phase(7'd12, 1'b0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chk.errors == 0 && chk.awaited_replies.size() == 0) begin
      $display("permutation_shuffle_engine: match");
    end else begin
      $display("permutation_shuffle_engine: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/pse_pkg.sv
hw/rtl/pse_ram.sv
hw/rtl/pse_ctrl.sv
hw/rtl/pse_dp.sv
hw/rtl/permutation_shuffle_engine.sv
verif/permutation_shuffle_engine_tb.sv
